[hdl/magnetometer_iron_calibration_defines.svh]
// ----------------------------------------------------------------------------
// Magnetometer iron calibration assertion macros
// Shared concurrent assertion helpers for the calibration block.
// ----------------------------------------------------------------------------
`ifndef MAGNETOMETER_IRON_CALIBRATION_DEFINES_SVH
`define MAGNETOMETER_IRON_CALIBRATION_DEFINES_SVH

// Generic clocked assertion with asynchronous active-low reset.
`define MIC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset.
`define MIC_ASSERT(lbl, prop, msg) `MIC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[hdl/mic_pkg.sv]
// ----------------------------------------------------------------------------
// Magnetometer iron calibration package
// Widths, register codes and shared types.
// ----------------------------------------------------------------------------
package mic_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int OUT_W     = 16;
  localparam int BIAS_W    = 32;
  localparam int COEF_W    = 20;
  localparam int ROW_W     = 3 * COEF_W;
  localparam int DIFF_W    = 37;
  localparam int PROD_W    = COEF_W + DIFF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int MAG_W     = 30;
  localparam int NORM_MSB  = MAG_W - 1;
  localparam int POS_W     = 6;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SSUM_W    = SQ_W + 2;
  localparam int ROOT_W    = SSUM_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int QUO_W     = 15;
  localparam int DIV_W     = MAG_W + QUO_W;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int CFG_AW    = 6;
  localparam int CFG_DW    = 64;

  localparam logic [QUO_W-1:0] OUT_ONE = 15'd16384;

  typedef enum logic [2:0] {
    REG_SOFT_ROW0 = 3'd0,
    REG_SOFT_ROW1 = 3'd1,
    REG_SOFT_ROW2 = 3'd2,
    REG_BIAS_X    = 3'd3,
    REG_BIAS_Y    = 3'd4,
    REG_BIAS_Z    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][2:0][COEF_W-1:0] coef;
    logic [2:0][BIAS_W-1:0]      bias;
  } mic_cfg_t;

  // Normalized magnitudes handed from the front to the back.
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  zero;
  } mic_vec_t;

endpackage

[hdl/mic_if.sv]
// ----------------------------------------------------------------------------
// Magnetometer iron calibration channels
// Valid/ready channels for samples in and calibrated vectors out.
// ----------------------------------------------------------------------------
interface mic_sample_if;
  import mic_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_x;
  logic signed [SAMPLE_W-1:0] sample_y;
  logic signed [SAMPLE_W-1:0] sample_z;
  modport source (output valid, sample_x, sample_y, sample_z, input ready);
  modport sink (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface mic_result_if;
  import mic_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_x;
  logic signed [OUT_W-1:0] out_y;
  logic signed [OUT_W-1:0] out_z;
  logic                    zero_vector;
  modport source (output valid, out_x, out_y, out_z, zero_vector, input ready);
  modport sink (input valid, out_x, out_y, out_z, zero_vector, output ready);
endinterface

[hdl/magnetometer_iron_calibration.sv]
// ----------------------------------------------------------------------------
// Magnetometer iron calibration
// Hard/soft-iron correction and unit normalization of magnetometer samples.
// ----------------------------------------------------------------------------
// Accepts one sample per clock while the output is not stalled and returns one
// Q2.14 unit vector per sample, in order. The path is 7 front-end stages
// (bias, matrix multiply, magnitude, leading-one search, shift), a 4-entry
// queue, and 50 back-end stages dominated by the 31-stage square root and the
// 15-stage per-axis divider. Registers are written over APB at 8*index and
// should only be changed while no transaction is in flight.
`include "magnetometer_iron_calibration_defines.svh"

module magnetometer_iron_calibration (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mic_pkg::CFG_AW-1:0] paddr,
  input  logic [mic_pkg::CFG_DW-1:0] pwdata,
  output logic [mic_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  mic_sample_if.sink                 in_if,
  mic_result_if.source               out_if
);
  import mic_pkg::*;

  logic [ROW_W-1:0]  row_q [3];
  logic [BIAS_W-1:0] bias_q [3];
  reg_idx_e          idx;
  logic              wr_en;
  mic_cfg_t          cfg;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[CFG_AW-1:3]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0]  <= ROW_W'(64'h10000);
      row_q[1]  <= ROW_W'(64'h10000) << COEF_W;
      row_q[2]  <= ROW_W'(64'h10000) << (2 * COEF_W);
      bias_q[0] <= '0;
      bias_q[1] <= '0;
      bias_q[2] <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SOFT_ROW0: row_q[0]  <= pwdata[ROW_W-1:0];
        REG_SOFT_ROW1: row_q[1]  <= pwdata[ROW_W-1:0];
        REG_SOFT_ROW2: row_q[2]  <= pwdata[ROW_W-1:0];
        REG_BIAS_X:    bias_q[0] <= pwdata[BIAS_W-1:0];
        REG_BIAS_Y:    bias_q[1] <= pwdata[BIAS_W-1:0];
        REG_BIAS_Z:    bias_q[2] <= pwdata[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SOFT_ROW0: prdata = CFG_DW'(row_q[0]);
      REG_SOFT_ROW1: prdata = CFG_DW'(row_q[1]);
      REG_SOFT_ROW2: prdata = CFG_DW'(row_q[2]);
      REG_BIAS_X:    prdata = CFG_DW'(bias_q[0]);
      REG_BIAS_Y:    prdata = CFG_DW'(bias_q[1]);
      REG_BIAS_Z:    prdata = CFG_DW'(bias_q[2]);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        cfg.coef[r][c] = row_q[r][c*COEF_W +: COEF_W];
      end
      cfg.bias[r] = bias_q[r];
    end
  end

  logic     q_in_valid;
  logic     q_in_ready;
  mic_vec_t q_in_data;
  logic     q_out_valid;
  logic     q_out_ready;
  mic_vec_t q_out_data;

  mic_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_if       (in_if),
    .vec_valid_o (q_in_valid),
    .vec_ready_i (q_in_ready),
    .vec_o       (q_in_data)
  );

  mic_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_in_valid),
    .push_ready_o (q_in_ready),
    .push_data_i  (q_in_data),
    .pop_valid_o  (q_out_valid),
    .pop_ready_i  (q_out_ready),
    .pop_data_o   (q_out_data)
  );

  mic_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vec_valid_i (q_out_valid),
    .vec_ready_o (q_out_ready),
    .vec_i       (q_out_data),
    .out_if      (out_if)
  );

  // A full queue always has a transaction to offer the back end
  `MIC_ASSERT(a_full_has_data, !q_in_ready |-> q_out_valid, "queue full but empty")

  // Zero-length vector gives an all-zero result
  `MIC_ASSERT(a_zero_out, out_if.valid && out_if.zero_vector |-> out_if.out_x == 0 && out_if.out_y == 0 && out_if.out_z == 0, "zero flag with nonzero axes")

  // Normalized x and z axes stay within one
  `MIC_ASSERT(a_unit_range, out_if.valid |-> out_if.out_x <= 16'sd16384 && out_if.out_x >= -16'sd16384 && out_if.out_z <= 16'sd16384 && out_if.out_z >= -16'sd16384, "axis out of unit range")

endmodule

[hdl/mic_front.sv]
// ----------------------------------------------------------------------------
// Calibration front end
// Bias removal, soft-iron matrix, magnitude and block normalization.
// ----------------------------------------------------------------------------
module mic_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mic_pkg::mic_cfg_t cfg_i,
  mic_sample_if.sink        in_if,
  output logic              vec_valid_o,
  input  logic              vec_ready_i,
  output mic_pkg::mic_vec_t vec_o
);
  import mic_pkg::*;

  localparam int NSTG = 7;

  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = vec_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_if.ready = rdy[0];
  assign vec_valid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_if.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage 1: D = 4*s - 25*b, exact
  logic signed [SAMPLE_W-1:0] smp [3];
  logic signed [BIAS_W-1:0]   bias [3];
  logic signed [DIFF_W-1:0]   bext [3];
  logic signed [DIFF_W-1:0]   d_d [3];
  logic signed [DIFF_W-1:0]   d_q [3];

  always_comb begin
    smp[0] = in_if.sample_x;
    smp[1] = in_if.sample_y;
    smp[2] = in_if.sample_z;
    for (int i = 0; i < 3; i++) begin
      bias[i] = cfg_i.bias[i];
      bext[i] = DIFF_W'(bias[i]);
      d_d[i]  = (DIFF_W'(smp[i]) <<< 2) - ((bext[i] <<< 4) + (bext[i] <<< 3) + bext[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) d_q <= d_d;
  end

  // Stage 2: products
  logic signed [COEF_W-1:0] coef [3][3];
  logic signed [PROD_W-1:0] p_d [3][3];
  logic signed [PROD_W-1:0] p_q [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef[i][j] = cfg_i.coef[i][j];
        p_d[i][j]  = PROD_W'(coef[i][j]) * PROD_W'(d_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) p_q <= p_d;
  end

  // Stage 3: row sums
  logic signed [SUM_W-1:0] r_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        r_q[i] <= SUM_W'(p_q[i][0]) + SUM_W'(p_q[i][1]) + SUM_W'(p_q[i][2]);
      end
    end
  end

  // Stage 4: magnitudes; msb of the OR equals msb of the largest
  logic [SUM_W-1:0] mag4_d [3];
  logic [SUM_W-1:0] mag4_q [3];
  logic [2:0]       neg4_q;
  logic [SUM_W-1:0] or4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag4_d[i] = r_q[i][SUM_W-1] ? SUM_W'(-r_q[i]) : SUM_W'(r_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      mag4_q <= mag4_d;
      for (int i = 0; i < 3; i++) neg4_q[i] <= r_q[i][SUM_W-1];
      or4_q  <= mag4_d[0] | mag4_d[1] | mag4_d[2];
    end
  end

  // Stage 5: highest nonzero byte
  logic [63:0]      orp;
  logic [2:0]       grp_d;
  logic [2:0]       grp5_q;
  logic [7:0]       byte5_q;
  logic [SUM_W-1:0] mag5_q [3];
  logic [2:0]       neg5_q;
  logic             zero5_q;

  always_comb begin
    orp   = 64'(or4_q);
    grp_d = '0;
    for (int g = 0; g < 8; g++) begin
      if (|orp[g*8 +: 8]) grp_d = 3'(g);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      grp5_q  <= grp_d;
      byte5_q <= orp[grp_d*8 +: 8];
      mag5_q  <= mag4_q;
      neg5_q  <= neg4_q;
      zero5_q <= (or4_q == '0);
    end
  end

  // Stage 6: bit within byte
  logic [2:0]       bit_d;
  logic [POS_W-1:0] p6_q;
  logic [SUM_W-1:0] mag6_q [3];
  logic [2:0]       neg6_q;
  logic             zero6_q;

  always_comb begin
    bit_d = '0;
    for (int b = 0; b < 8; b++) begin
      if (byte5_q[b]) bit_d = 3'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      p6_q    <= {grp5_q, bit_d};
      mag6_q  <= mag5_q;
      neg6_q  <= neg5_q;
      zero6_q <= zero5_q;
    end
  end

  // Stage 7: shift so the largest lands in [2^29, 2^30)
  mic_vec_t         vec_d;
  mic_vec_t         vec_q;
  logic [SUM_W-1:0] shf [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p6_q > POS_W'(NORM_MSB)) begin
        shf[i] = mag6_q[i] >> (p6_q - POS_W'(NORM_MSB));
      end else begin
        shf[i] = mag6_q[i] << (POS_W'(NORM_MSB) - p6_q);
      end
      vec_d.mag[i] = shf[i][MAG_W-1:0];
    end
    vec_d.neg  = neg6_q;
    vec_d.zero = zero6_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) vec_q <= vec_d;
  end

  assign vec_o = vec_q;

endmodule

[hdl/mic_queue.sv]
// ----------------------------------------------------------------------------
// Calibration decoupling queue
// Short FIFO between the front end and the normalization back end.
// ----------------------------------------------------------------------------
module mic_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  mic_pkg::mic_vec_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output mic_pkg::mic_vec_t pop_data_o
);
  import mic_pkg::*;

  mic_vec_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q;
  logic [QPTR_W-1:0]   rd_q;
  logic [QPTR_W:0]     cnt_q;
  logic                push;
  logic                pop;

  assign push_ready_o = (cnt_q != (QPTR_W+1)'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

[hdl/mic_back.sv]
// ----------------------------------------------------------------------------
// Calibration back end
// Sum of squares, pipelined integer square root, per-axis division, remap.
// ----------------------------------------------------------------------------
module mic_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vec_valid_i,
  output logic              vec_ready_o,
  input  mic_pkg::mic_vec_t vec_i,
  mic_result_if.source      out_if
);
  import mic_pkg::*;

  localparam int ST_SQ    = 0;
  localparam int ST_SUM   = 1;
  localparam int ST_SQRT  = 2;
  localparam int ST_SETUP = ST_SQRT + ROOT_W;
  localparam int ST_DIV   = ST_SETUP + 1;
  localparam int ST_OUT   = ST_DIV + QUO_W;
  localparam int NSTG     = ST_OUT + 1;

  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = out_if.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vec_ready_o  = rdy[0];
  assign out_if.valid = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= vec_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Magnitudes and signs travel alongside every stage but the last
  mic_vec_t ctx_q [NSTG-1];

  genvar k;
  for (k = 0; k < NSTG - 1; k++) begin : g_ctx
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (rdy[0]) ctx_q[0] <= vec_i;
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (rdy[k]) ctx_q[k] <= ctx_q[k-1];
      end
    end
  end

  // Squares, then their sum
  logic [SQ_W-1:0]   sq_q [3];
  logic [SSUM_W-1:0] s_q;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_SQ]) begin
      for (int l = 0; l < 3; l++) begin
        sq_q[l] <= SQ_W'(vec_i.mag[l]) * SQ_W'(vec_i.mag[l]);
      end
    end
    if (rdy[ST_SUM]) begin
      s_q <= SSUM_W'(sq_q[0]) + SSUM_W'(sq_q[1]) + SSUM_W'(sq_q[2]);
    end
  end

  // Square root, one result bit per stage
  logic [REM_W-1:0]  srem_q [ROOT_W];
  logic [ROOT_W-1:0] sroot_q [ROOT_W];
  logic [SSUM_W-1:0] sval_q [ROOT_W];

  genvar i;
  for (i = 0; i < ROOT_W; i++) begin : g_sqrt
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SSUM_W-1:0] val_in;
    logic [REM_W+1:0]  ext;
    logic [REM_W+1:0]  trial;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = s_q;
    end else begin : g_rest
      assign rem_in  = srem_q[i-1];
      assign root_in = sroot_q[i-1];
      assign val_in  = sval_q[i-1];
    end

    assign ext   = {rem_in, val_in[SSUM_W-1-2*i -: 2]};
    assign trial = (REM_W+2)'({root_in, 2'b01});

    always_ff @(posedge clk_i) begin
      if (rdy[ST_SQRT+i]) begin
        if (ext >= trial) begin
          srem_q[i]  <= REM_W'(ext - trial);
          sroot_q[i] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          srem_q[i]  <= REM_W'(ext);
          sroot_q[i] <= {root_in[ROOT_W-2:0], 1'b0};
        end
        sval_q[i] <= val_in;
      end
    end
  end

  // Division: entry 0 is the rounded dividend, one quotient bit per stage
  logic [DIV_W-1:0]  drem_q [QUO_W+1][3];
  logic [QUO_W-1:0]  dquo_q [QUO_W+1][3];
  logic [ROOT_W-1:0] dn_q [QUO_W+1];

  always_ff @(posedge clk_i) begin
    if (rdy[ST_SETUP]) begin
      for (int l = 0; l < 3; l++) begin
        drem_q[0][l] <= (DIV_W'(ctx_q[ST_SETUP-1].mag[l]) << (QUO_W - 1))
                      + DIV_W'(sroot_q[ROOT_W-1] >> 1);
        dquo_q[0][l] <= '0;
      end
      dn_q[0] <= sroot_q[ROOT_W-1];
    end
  end

  genvar j;
  for (j = 0; j < QUO_W; j++) begin : g_div
    logic [DIV_W:0] dvs;

    assign dvs = (DIV_W+1)'(dn_q[j]) << (QUO_W - 1 - j);

    always_ff @(posedge clk_i) begin
      if (rdy[ST_DIV+j]) begin
        for (int l = 0; l < 3; l++) begin
          if ({1'b0, drem_q[j][l]} >= dvs) begin
            drem_q[j+1][l] <= DIV_W'({1'b0, drem_q[j][l]} - dvs);
            dquo_q[j+1][l] <= dquo_q[j][l] | (QUO_W'(1) << (QUO_W - 1 - j));
          end else begin
            drem_q[j+1][l] <= drem_q[j][l];
            dquo_q[j+1][l] <= dquo_q[j][l];
          end
        end
        dn_q[j+1] <= dn_q[j];
      end
    end
  end

  // Sign, axis remap, zero case
  mic_vec_t                ctx_out;
  logic [QUO_W-1:0]        qc [3];
  logic signed [OUT_W-1:0] qs [3];
  logic signed [OUT_W-1:0] ox_q;
  logic signed [OUT_W-1:0] oy_q;
  logic signed [OUT_W-1:0] oz_q;
  logic                    zv_q;

  assign ctx_out = ctx_q[NSTG-2];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qc[l] = (dquo_q[QUO_W][l] > OUT_ONE) ? OUT_ONE : dquo_q[QUO_W][l];
      qs[l] = OUT_W'(qc[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_OUT]) begin
      if (ctx_out.zero) begin
        ox_q <= '0;
        oy_q <= '0;
        oz_q <= '0;
      end else begin
        ox_q <= ctx_out.neg[1] ? -qs[1] : qs[1];
        oy_q <= ctx_out.neg[0] ? -qs[0] : qs[0];
        oz_q <= ctx_out.neg[2] ? qs[2] : -qs[2];
      end
      zv_q <= ctx_out.zero;
    end
  end

  assign out_if.out_x       = ox_q;
  assign out_if.out_y       = oy_q;
  assign out_if.out_z       = oz_q;
  assign out_if.zero_vector = zv_q;

endmodule
